// ===== design/bfa_pkg.sv =====
// Shared types and constants for the bitmap first-fit allocator.
`timescale 1ns / 1ps
package bfa_pkg;

    typedef enum logic [1:0] {
        OP_ALLOC = 2'd0,
        OP_FREE  = 2'd1,
        OP_QUERY = 2'd2,
        OP_NONE  = 2'd3
    } t_opcode;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_ZERO_SIZE   = 3'd1,
        ST_NO_SPACE    = 3'd2,
        ST_BAD_ADDR    = 3'd3,
        ST_BAD_SIZE    = 3'd4,
        ST_BAD_MARKER  = 3'd5,
        ST_ALREADY_FREE = 3'd6
    } t_status;

    localparam logic [31:0] ALLOC_MARK  = 32'h1234ABCD;
    localparam logic [31:0] POISON_WORD = 32'hDEADBEEF;
    localparam int          UNIT_SHIFT  = 3;
    localparam int          MAP_BITS    = 8;

    localparam int          CFG_W   = 11;
    localparam int          BYTES_W = 14;
    localparam int          ADDR_W  = 10;
    localparam logic [CFG_W-1:0] CFG_RESET = 11'd1024;

endpackage

// ===== design/bitmap_first_fit_allocator_unit.sv =====
// Top level of the bitmap first-fit allocator: busy map and header stores with their sequencer.
// Allocate: scans the busy map one 8-unit map word at a time, writes the two header words, then
//   marks each covered map word with a read and a write. Query: scans the busy map words.
// Free: reads the size and marker headers, then checks, clears and poisons each unit released.
// One request is in work at a time. Reset is synchronous; it starts a clearing pass over both
// memories, during which no request is accepted.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_unit #(
    parameter int HEAP_UNITS = 1024
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cfg_we,
    input  logic [bfa_pkg::CFG_W-1:0]   i_cfg_wdata,
    input  logic                        i_s_axis_tvalid,
    output logic                        o_s_axis_tready,
    // opcode[1:0], request_bytes[15:2], release_unit[25:16], zero fill
    input  logic [31:0]                 i_s_axis_tdata,
    output logic                        o_m_axis_tvalid,
    input  logic                        i_m_axis_tready,
    // status[2:0], granted_unit[12:3], free_bytes[26:13], zero fill
    output logic [31:0]                 o_m_axis_tdata
);

    localparam int HW  = $clog2(HEAP_UNITS + 1);
    localparam int UW  = $clog2(HEAP_UNITS);
    localparam int NW  = (HEAP_UNITS + bfa_pkg::MAP_BITS - 1) / bfa_pkg::MAP_BITS;
    localparam int BAW = (NW > 1) ? $clog2(NW) : 1;

    typedef enum logic [3:0] {
        S_CLR, S_IDLE, S_ASCAN, S_AH0, S_AH1, S_MRD, S_MWR,
        S_FR1, S_FSZ, S_FMK, S_WRD, S_WCK, S_QSCAN, S_DONE
    } t_state;

    t_state                         r_state;
    logic [bfa_pkg::CFG_W-1:0]      r_cfg;
    logic [HW-1:0]                  r_h;
    logic [HW-1:0]                  r_addr;
    logic [HW-1:0]                  r_need;
    logic [HW-1:0]                  r_units;
    logic [HW-1:0]                  r_wi;
    logic [HW-1:0]                  r_pw;
    logic                           r_pend;
    logic [HW-1:0]                  r_run;
    logic [HW-1:0]                  r_cnt;
    logic [HW-1:0]                  r_start;
    logic [HW-1:0]                  r_last;
    logic [HW:0]                    r_u;
    logic [HW:0]                    r_end;
    bfa_pkg::t_status               r_rstat;
    logic [bfa_pkg::ADDR_W-1:0]     r_rgrant;
    logic [bfa_pkg::BYTES_W-1:0]    r_rfree;
    logic                           r_ov;
    bfa_pkg::t_status               r_ostat;
    logic [bfa_pkg::ADDR_W-1:0]     r_ogrant;
    logic [bfa_pkg::BYTES_W-1:0]    r_ofree;

    logic [bfa_pkg::MAP_BITS-1:0]   busy_mem [NW];
    logic [31:0]                    hdr_mem [HEAP_UNITS];
    logic [bfa_pkg::MAP_BITS-1:0]   r_bdata;
    logic [31:0]                    r_hdata;

    logic                           busy_we;
    logic [BAW-1:0]                 busy_waddr;
    logic [BAW-1:0]                 busy_raddr;
    logic [bfa_pkg::MAP_BITS-1:0]   busy_wdata;
    logic                           hdr_we;
    logic [UW-1:0]                  hdr_waddr;
    logic [UW-1:0]                  hdr_raddr;
    logic [31:0]                    hdr_wdata;

    logic [1:0]                     in_op;
    logic [bfa_pkg::BYTES_W-1:0]    in_bytes;
    logic [bfa_pkg::ADDR_W-1:0]     in_addr;
    logic [31:0]                    hcap;
    logic [HW-1:0]                  cur_h;
    logic [15:0]                    in_need;
    logic [HW-1:0]                  lastw;
    logic                           accept;

    logic [HW-1:0]                  sc_run;
    logic                           sc_found;
    logic [HW-1:0]                  sc_start;
    logic [HW-1:0]                  sc_cnt;
    logic [bfa_pkg::MAP_BITS-1:0]   mk_mask;
    logic [HW-1:0]                  w_word;
    logic [31:0]                    grant_w;
    logic [31:0]                    free_w;

    assign in_op    = i_s_axis_tdata[1:0];
    assign in_bytes = i_s_axis_tdata[15:2];
    assign in_addr  = i_s_axis_tdata[25:16];
    assign hcap     = (32'(r_cfg) > 32'(HEAP_UNITS)) ? 32'(HEAP_UNITS) : 32'(r_cfg);
    assign cur_h    = HW'(hcap);
    assign in_need  = (16'(in_bytes) + 16'd23) >> bfa_pkg::UNIT_SHIFT;
    assign lastw    = (r_h == '0) ? '0 : ((r_h - HW'(1)) >> bfa_pkg::UNIT_SHIFT);
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign accept   = i_s_axis_tvalid && o_s_axis_tready;
    assign w_word   = HW'(r_u >> bfa_pkg::UNIT_SHIFT);
    assign grant_w  = 32'(r_start) + 32'd2;
    assign free_w   = 32'(sc_cnt) << bfa_pkg::UNIT_SHIFT;

    assign o_m_axis_tvalid = r_ov;
    assign o_m_axis_tdata  = {5'd0, r_ofree, r_ogrant, r_ostat};

    always_comb begin
        logic [HW:0] v_u;
        logic        v_fr;
        sc_run   = r_run;
        sc_found = 1'b0;
        sc_start = '0;
        sc_cnt   = r_cnt;
        for (int j = 0; j < bfa_pkg::MAP_BITS; j++) begin
            v_u  = (HW+1)'({r_pw, 3'b000}) + (HW+1)'(j);
            v_fr = (v_u < {1'b0, r_h}) && !r_bdata[j];
            sc_run = v_fr ? sc_run + HW'(1) : '0;
            sc_cnt = sc_cnt + HW'(v_fr);
            if (!sc_found && v_fr && sc_run == r_need) begin
                sc_found = 1'b1;
                sc_start = HW'(v_u + (HW+1)'(1) - (HW+1)'(r_need));
            end
        end
    end

    always_comb begin
        logic [HW+2:0] v_m;
        for (int j = 0; j < bfa_pkg::MAP_BITS; j++) begin
            v_m = (HW+3)'({r_wi, 3'b000}) + (HW+3)'(j);
            mk_mask[j] = (v_m >= (HW+3)'(r_start)) && (v_m <= (HW+3)'(r_last));
        end
    end

    always_comb begin
        busy_we    = 1'b0;
        busy_waddr = BAW'(r_wi);
        busy_wdata = '0;
        busy_raddr = BAW'(r_wi);
        hdr_we     = 1'b0;
        hdr_waddr  = UW'(r_u);
        hdr_wdata  = '0;
        hdr_raddr  = (r_state == S_FR1) ? UW'(r_addr - HW'(1)) : UW'(r_addr - HW'(2));
        unique case (r_state)
            S_CLR: begin
                hdr_we     = 1'b1;
                busy_we    = (r_u < (HW+1)'(NW));
                busy_waddr = BAW'(r_u);
            end
            S_AH0: begin
                hdr_we    = 1'b1;
                hdr_waddr = UW'(r_start);
                hdr_wdata = bfa_pkg::ALLOC_MARK;
            end
            S_AH1: begin
                hdr_we    = 1'b1;
                hdr_waddr = UW'(r_start + HW'(1));
                hdr_wdata = 32'(r_units);
            end
            S_MWR: begin
                busy_we    = 1'b1;
                busy_wdata = r_bdata | mk_mask;
            end
            S_WRD: begin
                busy_raddr = BAW'(w_word);
            end
            S_WCK: begin
                if ((r_u < (HW+1)'(r_h)) && r_bdata[r_u[2:0]]) begin
                    busy_we    = 1'b1;
                    busy_waddr = BAW'(w_word);
                    busy_wdata = r_bdata & ~(bfa_pkg::MAP_BITS'(1) << r_u[2:0]);
                    hdr_we     = 1'b1;
                    hdr_wdata  = bfa_pkg::POISON_WORD;
                end
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_bdata <= busy_mem[busy_raddr];
        if (busy_we) begin
            busy_mem[busy_waddr] <= busy_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_hdata <= hdr_mem[hdr_raddr];
        if (hdr_we) begin
            hdr_mem[hdr_waddr] <= hdr_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_cfg   <= bfa_pkg::CFG_RESET;
            r_u     <= '0;
            r_ov    <= 1'b0;
            r_pend  <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_cfg <= i_cfg_wdata;
            end
            if (i_m_axis_tready && r_state != S_DONE) begin
                r_ov <= 1'b0;
            end
            unique case (r_state)
                S_CLR: begin
                    r_u <= r_u + (HW+1)'(1);
                    if (r_u == (HW+1)'(HEAP_UNITS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (accept) begin
                        r_h      <= cur_h;
                        r_wi     <= '0;
                        r_pend   <= 1'b0;
                        r_run    <= '0;
                        r_cnt    <= '0;
                        r_rgrant <= '0;
                        r_rfree  <= '0;
                        r_rstat  <= bfa_pkg::ST_OK;
                        r_state  <= S_DONE;
                        unique case (in_op)
                            bfa_pkg::OP_ALLOC: begin
                                r_need  <= HW'(in_need);
                                r_units <= HW'(in_need - 16'd2);
                                if (in_bytes == '0) begin
                                    r_rstat <= bfa_pkg::ST_ZERO_SIZE;
                                end else if (32'(in_need) > 32'(cur_h)) begin
                                    r_rstat <= bfa_pkg::ST_NO_SPACE;
                                end else begin
                                    r_state <= S_ASCAN;
                                end
                            end
                            bfa_pkg::OP_FREE: begin
                                r_addr <= HW'(in_addr);
                                if (in_addr < 10'd2 || 32'(in_addr) >= 32'(cur_h)) begin
                                    r_rstat <= bfa_pkg::ST_BAD_ADDR;
                                end else begin
                                    r_state <= S_FR1;
                                end
                            end
                            bfa_pkg::OP_QUERY: begin
                                r_state <= S_QSCAN;
                            end
                            default: begin
                            end
                        endcase
                    end
                end
                S_ASCAN, S_QSCAN: begin
                    if (r_wi <= lastw) begin
                        r_wi <= r_wi + HW'(1);
                    end
                    r_pend <= (r_wi <= lastw);
                    r_pw   <= r_wi;
                    if (r_pend) begin
                        r_run <= sc_run;
                        r_cnt <= sc_cnt;
                        if (r_state == S_ASCAN && sc_found) begin
                            r_start <= sc_start;
                            r_last  <= sc_start + r_need - HW'(1);
                            r_state <= S_AH0;
                        end else if (r_pw == lastw) begin
                            if (r_state == S_ASCAN) begin
                                r_rstat <= bfa_pkg::ST_NO_SPACE;
                            end else begin
                                r_rfree <= free_w[bfa_pkg::BYTES_W-1:0];
                            end
                            r_state <= S_DONE;
                        end
                    end
                end
                S_AH0: begin
                    r_wi    <= r_start >> bfa_pkg::UNIT_SHIFT;
                    r_state <= S_AH1;
                end
                S_AH1: begin
                    r_state <= S_MRD;
                end
                S_MRD: begin
                    r_state <= S_MWR;
                end
                S_MWR: begin
                    if (r_wi == (r_last >> bfa_pkg::UNIT_SHIFT)) begin
                        r_rgrant <= grant_w[bfa_pkg::ADDR_W-1:0];
                        r_state  <= S_DONE;
                    end else begin
                        r_wi    <= r_wi + HW'(1);
                        r_state <= S_MRD;
                    end
                end
                S_FR1: begin
                    r_state <= S_FSZ;
                end
                S_FSZ: begin
                    if (r_hdata == '0 || r_hdata > 32'(r_h) - 32'd2) begin
                        r_rstat <= bfa_pkg::ST_BAD_SIZE;
                        r_state <= S_DONE;
                    end else begin
                        r_end   <= (HW+1)'(r_addr) + (HW+1)'(r_hdata);
                        r_u     <= (HW+1)'(r_addr) - (HW+1)'(2);
                        r_state <= S_FMK;
                    end
                end
                S_FMK: begin
                    if (r_hdata != bfa_pkg::ALLOC_MARK) begin
                        r_rstat <= bfa_pkg::ST_BAD_MARKER;
                        r_state <= S_DONE;
                    end else begin
                        r_state <= S_WRD;
                    end
                end
                S_WRD: begin
                    r_state <= S_WCK;
                end
                S_WCK: begin
                    if (!((r_u < (HW+1)'(r_h)) && r_bdata[r_u[2:0]])) begin
                        r_rstat <= bfa_pkg::ST_ALREADY_FREE;
                        r_state <= S_DONE;
                    end else if (r_u + (HW+1)'(1) == r_end) begin
                        r_state <= S_DONE;
                    end else begin
                        r_u     <= r_u + (HW+1)'(1);
                        r_state <= S_WRD;
                    end
                end
                S_DONE: begin
                    if (!r_ov || i_m_axis_tready) begin
                        r_ov     <= 1'b1;
                        r_ostat  <= r_rstat;
                        r_ogrant <= r_rgrant;
                        r_ofree  <= r_rfree;
                        r_state  <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> (r_state != S_IDLE))
        else $error("request accepted without leaving idle");

    a_grant_above_header: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_ostat == bfa_pkg::ST_OK && r_ogrant != '0) |-> (r_ogrant >= 10'd2))
        else $error("granted unit overlaps the header units");

    a_release_in_heap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_WCK && busy_we) |-> (r_u < (HW+1)'(r_h)))
        else $error("release writes a unit beyond the heap");

endmodule

// ===== tb/bitmap_first_fit_allocator_unit_tb.sv =====
// Self-checking testbench for the bitmap first-fit allocator with its own allocator predictor.
`timescale 1ns / 1ps
module bitmap_first_fit_allocator_unit_tb;

    localparam int UNITS      = 1024;
    localparam int MAX_CYCLES = 6000000;

    typedef struct {
        bfa_pkg::t_status status;
        logic [9:0]       granted;
        logic [13:0]      avail;
    } t_reply;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_cfg_we;
    logic [bfa_pkg::CFG_W-1:0]  i_cfg_wdata;
    logic                       i_s_axis_tvalid;
    logic                       o_s_axis_tready;
    logic [31:0]                i_s_axis_tdata;
    logic                       o_m_axis_tvalid;
    logic                       i_m_axis_tready;
    logic [31:0]                o_m_axis_tdata;

    // Allocator state as the predictor sees it.
    bit                         unit_taken [UNITS];
    logic [31:0]                header_mem [UNITS];
    logic [bfa_pkg::CFG_W-1:0]  heap_size;

    t_reply            pending_replies [$];
    int                live_grants [$];
    int                fail_count;
    int                cycle_count;
    int                send_idle_pct;
    int                recv_idle_pct;
    int                stall_left;

    bitmap_first_fit_allocator_unit #(.HEAP_UNITS(UNITS)) u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_wdata     (i_cfg_wdata),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES) begin
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic int heap_limit();
        return (heap_size > UNITS) ? UNITS : int'(heap_size);
    endfunction

    function automatic t_reply predict_allocator(bfa_pkg::t_opcode op, int bytes, int unit);
        t_reply r;
        int     h;
        int     units;
        int     need;
        int     run;
        int     start;
        int     size;
        int     count;
        r.status  = bfa_pkg::ST_OK;
        r.granted = '0;
        r.avail   = '0;
        h         = heap_limit();
        unique case (op)
            bfa_pkg::OP_ALLOC: begin
                units = (bytes + 7) >> bfa_pkg::UNIT_SHIFT;
                need  = units + 2;
                run   = 0;
                start = 0;
                if (bytes == 0) begin
                    r.status = bfa_pkg::ST_ZERO_SIZE;
                end else begin
                    r.status = bfa_pkg::ST_NO_SPACE;
                    if (need <= h) begin
                        for (int i = 0; i < h; i++) begin
                            if (unit_taken[i]) begin
                                run = 0;
                            end else begin
                                if (run == 0) start = i;
                                run++;
                                if (run >= need) begin
                                    header_mem[start]     = bfa_pkg::ALLOC_MARK;
                                    header_mem[start + 1] = units;
                                    for (int k = 0; k < need; k++) unit_taken[start + k] = 1'b1;
                                    r.granted = 10'(start + 2);
                                    r.status  = bfa_pkg::ST_OK;
                                    break;
                                end
                            end
                        end
                    end
                end
            end
            bfa_pkg::OP_FREE: begin
                if (unit < 2 || unit >= h) begin
                    r.status = bfa_pkg::ST_BAD_ADDR;
                end else begin
                    size = int'(header_mem[unit - 1]);
                    if (h < 3 || header_mem[unit - 1] < 1 || header_mem[unit - 1] > h - 2) begin
                        r.status = bfa_pkg::ST_BAD_SIZE;
                    end else if (header_mem[unit - 2] != bfa_pkg::ALLOC_MARK) begin
                        r.status = bfa_pkg::ST_BAD_MARKER;
                    end else begin
                        for (int u = unit - 2; u < unit + size; u++) begin
                            if (!(u < h && unit_taken[u])) begin
                                r.status = bfa_pkg::ST_ALREADY_FREE;
                                break;
                            end
                            unit_taken[u] = 1'b0;
                            header_mem[u] = bfa_pkg::POISON_WORD;
                        end
                    end
                end
            end
            bfa_pkg::OP_QUERY: begin
                count = 0;
                for (int i = 0; i < h; i++) if (!unit_taken[i]) count++;
                r.avail = 14'(count * 8);
            end
            default: ;
        endcase
        return r;
    endfunction

    task automatic send_word(bfa_pkg::t_opcode op, int bytes, int unit);
        t_reply r;
        if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {6'b0, unit[9:0], bytes[13:0], op};
        do @(posedge i_clk); while (!o_s_axis_tready);
        r = predict_allocator(op, bytes, unit);
        pending_replies.push_back(r);
        if (op == bfa_pkg::OP_ALLOC && r.status == bfa_pkg::ST_OK) begin
            live_grants.push_back(int'(r.granted));
        end
    endtask

    task automatic wait_idle();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_heap_units(int value);
        wait_idle();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value[bfa_pkg::CFG_W-1:0];
        @(posedge i_clk);
        heap_size = value[bfa_pkg::CFG_W-1:0];
        i_cfg_we  <= 1'b0;
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else begin
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (pending_replies.size() == 0) begin
                    $error("Unexpected word 0x%08h", o_m_axis_tdata);
                    fail_count++;
                end else begin
                    t_reply r;
                    r = pending_replies.pop_front();
                    if (o_m_axis_tdata[2:0] != r.status) begin
                        $error("status: expected %0d, got %0d", r.status, o_m_axis_tdata[2:0]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[12:3] != r.granted) begin
                        $error("granted_unit: expected %0d, got %0d",
                               r.granted, o_m_axis_tdata[12:3]);
                        fail_count++;
                    end
                    if (o_m_axis_tdata[26:13] != r.avail) begin
                        $error("free_bytes: expected %0d, got %0d",
                               r.avail, o_m_axis_tdata[26:13]);
                        fail_count++;
                    end
                end
            end
            if (stall_left > 0) begin
                stall_left      <= stall_left - 1;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic test_basic_requests();
        send_word(bfa_pkg::OP_QUERY, 0, 0);
        send_word(bfa_pkg::OP_ALLOC, 0, 0);
        send_word(bfa_pkg::OP_ALLOC, 1, 0);
        send_word(bfa_pkg::OP_ALLOC, 16, 0);
        send_word(bfa_pkg::OP_ALLOC, 8192, 0);
        send_word(bfa_pkg::OP_ALLOC, 16383, 1023);
        send_word(bfa_pkg::OP_NONE, 16383, 1023);
        send_word(bfa_pkg::OP_FREE, 0, 0);
        send_word(bfa_pkg::OP_FREE, 0, 1);
        send_word(bfa_pkg::OP_FREE, 0, 1023);
        send_word(bfa_pkg::OP_FREE, 0, 3);
        send_word(bfa_pkg::OP_QUERY, 16383, 1023);
    endtask

    // The block at data unit 5 reaches past a heap shrunk to six units.
    task automatic test_walk_past_heap();
        set_heap_units(6);
        send_word(bfa_pkg::OP_FREE, 0, 5);
        set_heap_units(1024);
        send_word(bfa_pkg::OP_FREE, 0, 2);
        send_word(bfa_pkg::OP_FREE, 0, 2);
        send_word(bfa_pkg::OP_FREE, 0, 4);
        send_word(bfa_pkg::OP_QUERY, 0, 0);
    endtask

    task automatic test_heap_extremes();
        set_heap_units(0);
        send_word(bfa_pkg::OP_FREE, 0, 2);
        send_word(bfa_pkg::OP_ALLOC, 1, 0);
        send_word(bfa_pkg::OP_QUERY, 0, 0);
        set_heap_units(2047);
        send_word(bfa_pkg::OP_ALLOC, 8184, 0);
        send_word(bfa_pkg::OP_QUERY, 0, 0);
        set_heap_units(3);
        send_word(bfa_pkg::OP_ALLOC, 8, 0);
        send_word(bfa_pkg::OP_FREE, 0, 2);
        send_word(bfa_pkg::OP_QUERY, 0, 0);
        set_heap_units(1024);
    endtask

    task automatic test_output_stall();
        send_idle_pct = 0;
        stall_left   <= 3000;
        for (int i = 0; i < 8; i++) send_word(bfa_pkg::OP_QUERY, 0, 0);
        wait_idle();
    endtask

    task automatic test_random_traffic(int count, int heap, int s_pct, int r_pct);
        int pick;
        int idx;
        int bytes;
        set_heap_units(heap);
        live_grants.delete();
        send_idle_pct = s_pct;
        recv_idle_pct = r_pct;
        for (int n = 0; n < count; n++) begin
            pick = $urandom_range(99);
            if (pick < 45) begin
                pick = $urandom_range(99);
                if (pick < 3) bytes = 0;
                else if (pick < 7) bytes = $urandom_range(16383);
                else if (pick < 12) bytes = $urandom_range(8192);
                else bytes = $urandom_range(8 * $urandom_range(1, 12), 1);
                send_word(bfa_pkg::OP_ALLOC, bytes, $urandom_range(1023));
            end else if (pick < 82 && live_grants.size() != 0) begin
                idx = $urandom_range(live_grants.size() - 1);
                send_word(bfa_pkg::OP_FREE, $urandom_range(16383), live_grants[idx]);
                live_grants.delete(idx);
            end else if (pick < 88) begin
                send_word(bfa_pkg::OP_FREE, $urandom_range(16383), $urandom_range(1023));
            end else if (pick < 96) begin
                send_word(bfa_pkg::OP_QUERY, $urandom_range(16383), $urandom_range(1023));
            end else begin
                send_word(bfa_pkg::OP_NONE, $urandom_range(16383), $urandom_range(1023));
            end
        end
    endtask

    initial begin
        for (int i = 0; i < UNITS; i++) begin
            unit_taken[i] = 1'b0;
            header_mem[i] = '0;
        end
        heap_size       = bfa_pkg::CFG_RESET;
        fail_count      = 0;
        cycle_count     = 0;
        send_idle_pct   = 29;
        recv_idle_pct   = 58;
        stall_left      = 0;
        i_rst_n         = 1'b0;
        i_cfg_we        = 1'b0;
        i_cfg_wdata     = '0;
        i_s_axis_tvalid = 1'b0;
        i_s_axis_tdata  = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_basic_requests();
        test_walk_past_heap();
        test_heap_extremes();
        test_output_stall();
        test_random_traffic(130, 1024, 29, 58);
        test_random_traffic(120, 64, 29, 58);
        test_random_traffic(130, 2047, 58, 29);
        test_random_traffic(120, 150, 58, 29);
        test_random_traffic(80, 3, 0, 0);
        test_random_traffic(170, 1024, 0, 0);

        wait_idle();
        repeat (100) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== files.f =====
design/bfa_pkg.sv
design/bitmap_first_fit_allocator_unit.sv
tb/bitmap_first_fit_allocator_unit_tb.sv
